>>> hw/rtl/fixed_point_line_rasterizer_top_macros.svh
// Assertion macros used by the line rasterizer controller RTL.
`ifndef FIXED_POINT_LINE_RASTERIZER_TOP_MACROS_SVH
`define FIXED_POINT_LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPLR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fplr: implication check failed");

// Next-cycle implication, checked outside reset.
`define FPLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fplr: next-cycle check failed");

`endif

>>> hw/rtl/fplr_pkg.sv
`timescale 1ns / 1ps
package fplr_pkg;

  // Port field widths
  localparam int IN_COORD_W  = 6;
  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 12;
  localparam int WIDTH_W     = 7;
  localparam int IN_TDATA_W  = 4 * IN_COORD_W + COLOR_W;
  localparam int OUT_TDATA_W = ADDR_W + 2 * IN_COORD_W + COLOR_W;

  localparam logic [WIDTH_W-1:0] FB_WIDTH_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // capture command, set up divider and accumulator
    logic div_step;  // one restoring division step
    logic emit;      // load output register, advance along the line
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current division step is the final one
    logic out_last;  // output register holds the final pixel
  } sts_t;

endpackage

>>> hw/rtl/fplr_ctrl.sv
`timescale 1ns / 1ps
`include "fixed_point_line_rasterizer_top_macros.svh"
module fplr_ctrl
  import fplr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.emit   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_tready) begin
          if (sts.out_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.emit = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `FPLR_ASSERT_NEXT(a_accept_to_div, clk, rst, s_tvalid && s_tready, state == ST_DIV)
  `FPLR_ASSERT_NEXT(a_div_to_load, clk, rst, state == ST_DIV && sts.div_last, state == ST_LOAD)
  `FPLR_ASSERT_NEXT(a_load_to_emit, clk, rst, state == ST_LOAD, m_tvalid)
  `FPLR_ASSERT_NEXT(a_last_to_idle, clk, rst, m_tvalid && m_tready && sts.out_last, s_tready)
  `FPLR_ASSERT_IMPL(a_emit_only_out, clk, rst, cmd.emit, state == ST_LOAD || m_tready)

endmodule

>>> hw/rtl/fplr_datapath.sv
`timescale 1ns / 1ps
module fplr_datapath
  import fplr_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16,
  parameter int COLOR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [WIDTH_W-1:0]     cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int DCNT_W = $clog2(ACC_W);
  localparam int PROD_W = IN_COORD_W + WIDTH_W;
  localparam logic [COLOR_W-1:0] COLOR_MASK = COLOR_W'((64'd1 << COLOR_BITS) - 64'd1);

  // Command decode
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  ymaj_in;
  logic [COORD_BITS-1:0] amaj_in, nmag_in, mstart_in, nstart_in;
  logic                  dir_neg_in, nspan_neg_in;

  assign sx = s_tdata[COORD_BITS-1:0];
  assign sy = s_tdata[IN_COORD_W +: COORD_BITS];
  assign ex = s_tdata[2*IN_COORD_W +: COORD_BITS];
  assign ey = s_tdata[3*IN_COORD_W +: COORD_BITS];

  always_comb begin
    adx          = (ex >= sx) ? (ex - sx) : (sx - ex);
    ady          = (ey >= sy) ? (ey - sy) : (sy - ey);
    ymaj_in      = (ady > adx);
    amaj_in      = ymaj_in ? ady : adx;
    nmag_in      = ymaj_in ? adx : ady;
    mstart_in    = ymaj_in ? sy : sx;
    nstart_in    = ymaj_in ? sx : sy;
    dir_neg_in   = ymaj_in ? (ey < sy) : (ex < sx);
    nspan_neg_in = ymaj_in ? (ex < sx) : (ey < sy);
  end

  // Line state
  logic [WIDTH_W-1:0]    fb_width;
  logic                  ymaj;
  logic                  dir_neg;
  logic                  step_neg;
  logic                  step_zero;
  logic [COORD_BITS-1:0] amaj;
  logic [COORD_BITS-1:0] count;
  logic [COORD_BITS-1:0] maj;
  logic [ACC_W-1:0]      acc;
  logic [COLOR_W-1:0]    color;

  // Divider: dividend shifts out of dq while quotient bits shift in
  logic [ACC_W-1:0]      dq;
  logic [COORD_BITS-1:0] rem;
  logic [DCNT_W-1:0]     div_cnt;
  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    shifted = {rem, dq[ACC_W-1]};
    ge      = (shifted >= {1'b0, amaj});
    diff    = shifted - {1'b0, amaj};
  end

  // Pixel at the current position
  logic [ACC_W-1:0]      step;
  logic [COORD_BITS-1:0] mn, px, py;
  logic [PROD_W-1:0]     prod;
  logic [ADDR_W-1:0]     addr;

  always_comb begin
    step = step_zero ? '0 : (step_neg ? (-dq) : dq);
    mn   = acc[ACC_W-1:FRAC_BITS];
    px   = ymaj ? mn : maj;
    py   = ymaj ? maj : mn;
    prod = PROD_W'(py) * PROD_W'(fb_width);
    addr = ADDR_W'(prod + PROD_W'(px));
  end

  // Output register
  logic [ADDR_W-1:0]     out_addr;
  logic [IN_COORD_W-1:0] out_x, out_y;
  logic [COLOR_W-1:0]    out_color;
  logic                  out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width <= FB_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      fb_width <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ymaj      <= ymaj_in;
      dir_neg   <= dir_neg_in;
      step_neg  <= nspan_neg_in;
      step_zero <= (amaj_in == '0);
      amaj      <= amaj_in;
      count     <= amaj_in;
      maj       <= mstart_in;
      acc       <= {nstart_in, 1'b1, {(FRAC_BITS-1){1'b0}}};
      color     <= s_tdata[4*IN_COORD_W +: COLOR_W] & COLOR_MASK;
      dq        <= {nmag_in, {FRAC_BITS{1'b0}}};
      rem       <= '0;
      div_cnt   <= DCNT_W'(ACC_W - 1);
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      dq      <= {dq[ACC_W-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end else if (cmd.emit) begin
      out_addr  <= addr;
      out_x     <= IN_COORD_W'(px);
      out_y     <= IN_COORD_W'(py);
      out_color <= color;
      out_last  <= (count == '0);
      count     <= count - 1'b1;
      maj       <= dir_neg ? (maj - 1'b1) : (maj + 1'b1);
      acc       <= acc + step;
    end
  end

  assign sts.div_last = (div_cnt == '0);
  assign sts.out_last = out_last;
  assign m_tdata      = {out_color, out_y, out_x, out_addr};
  assign m_tlast      = out_last;

endmodule

>>> hw/rtl/fixed_point_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Each accepted command first runs the bit-serial slope divider (one quotient bit a cycle),
// then emits one pixel per cycle while m_tready is high; a pixel that is not taken is held in
// the output register until m_tready rises.
// Commands are taken one at a time; the next is accepted the cycle after the last pixel leaves.
// Reset (rst, synchronous, active high) idles the controller and sets fb_width to 64.
module fixed_point_line_rasterizer_top
  import fplr_pkg::*;
#(
  parameter int COORD_BITS = 6,   // coordinate bits used, 2 to 6
  parameter int FRAC_BITS  = 16,  // fraction bits of the minor-axis accumulator, 8 to 16
  parameter int COLOR_BITS = 32   // color bits passed through, 1 to 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // fb_width register write
  input  logic                   cfg_wr_en,
  input  logic [WIDTH_W-1:0]     cfg_wr_data,
  // Line command in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, pixel_color
  // Pixel write out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // pixel_addr, pixel_x, pixel_y, write_color
  output logic                   m_tlast    // last_pixel
);

  // The controller sequences each command through three phases:
  //   capture  - decode the endpoints, pick the major axis, preload the divider
  //   divide   - restoring division of (minor span << FRAC_BITS) by the major span
  //   emit     - step the major coordinate, add the slope to the COORD_BITS.FRAC_BITS
  //              (6.16 by default) accumulator, and hold each pixel in the output register until taken
  cmd_t cmd;
  sts_t sts;

  fplr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath holds the width register, the divider, the accumulator and the
  // output register; address is y times fb_width plus x, wrapped to 12 bits.
  fplr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
